// File: sv/sha256_block_compression_defines.svh
// Assertion macros used by the SHA-256 compression RTL.
`ifndef SHA256_BLOCK_COMPRESSION_DEFINES_SVH
`define SHA256_BLOCK_COMPRESSION_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHA256C_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHA256C_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: sv/sha256c_pkg.sv
// Types, constants and round table for the SHA-256 block compression.
`timescale 1ns / 1ps
`default_nettype none

package sha256c_pkg;

   localparam int unsigned WORD_BITS  = 32;
   localparam int unsigned BLOCK_LEN  = 16;
   localparam int unsigned ROUNDS     = 64;
   localparam int unsigned STATE_LEN  = 8;
   localparam int unsigned DIGEST_BITS = STATE_LEN * WORD_BITS;

   localparam logic [3:0] LAST_POSITION = 4'd15;
   localparam logic [5:0] LAST_ROUND    = 6'd63;

   typedef logic [WORD_BITS-1:0] word_type;

   // Working variables of the compression, a through h.
   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
      word_type f;
      word_type g;
      word_type h;
   } sha256c_vars_type;

   // Schedule taps that one round reads from the sixteen-word window.
   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w9;
      word_type w14;
   } sha256c_taps_type;

   typedef enum logic [1:0] {
      ST_COLLECT,
      ST_ROUND,
      ST_FINAL,
      ST_EMIT
   } sha256c_state_type;

   localparam word_type INIT_VALUE [STATE_LEN] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

endpackage

`default_nettype wire

// File: sv/sha256c_round.sv
// One SHA-256 round and one message schedule expansion step.
`timescale 1ns / 1ps
`default_nettype none

module sha256c_round
   import sha256c_pkg::*;
(
   input  var sha256c_vars_type vars_cur,
   input  var sha256c_taps_type taps,
   input  var word_type         round_k,
   output var sha256c_vars_type vars_nxt,
   output var word_type         sched_word
);

   function automatic word_type rotr(input word_type x, input int unsigned n);
      rotr = (x >> n) | (x << (WORD_BITS - n));
   endfunction

   word_type small0;
   word_type small1;
   word_type big0;
   word_type big1;
   word_type choose;
   word_type majority;
   word_type temp1;
   word_type temp2;

   always_comb begin
      small0 = rotr(taps.w1, 7) ^ rotr(taps.w1, 18) ^ (taps.w1 >> 3);
      small1 = rotr(taps.w14, 17) ^ rotr(taps.w14, 19) ^ (taps.w14 >> 10);
      sched_word = taps.w0 + small0 + taps.w9 + small1;
   end

   always_comb begin
      big1     = rotr(vars_cur.e, 6) ^ rotr(vars_cur.e, 11) ^ rotr(vars_cur.e, 25);
      choose   = (vars_cur.e & vars_cur.f) ^ (~vars_cur.e & vars_cur.g);
      temp1    = vars_cur.h + big1 + choose + round_k + taps.w0;
      big0     = rotr(vars_cur.a, 2) ^ rotr(vars_cur.a, 13) ^ rotr(vars_cur.a, 22);
      majority = (vars_cur.a & vars_cur.b) ^ (vars_cur.a & vars_cur.c)
               ^ (vars_cur.b & vars_cur.c);
      temp2    = big0 + majority;

      vars_nxt.h = vars_cur.g;
      vars_nxt.g = vars_cur.f;
      vars_nxt.f = vars_cur.e;
      vars_nxt.e = vars_cur.d + temp1;
      vars_nxt.d = vars_cur.c;
      vars_nxt.c = vars_cur.b;
      vars_nxt.b = vars_cur.a;
      vars_nxt.a = temp1 + temp2;
   end

endmodule

`default_nettype wire

// File: sv/sha256_block_compression.sv
// Top level of the streaming SHA-256 block compression.
`timescale 1ns / 1ps
`default_nettype none

// Takes a padded message as 32-bit big-endian words, one beat per word, and
// keeps the SHA-256 chaining value across blocks. tuser set on a beat loads
// the standard initial value and starts a new block with that word; tlast
// marks the final word, after which the eight-word digest is given as one
// result beat. Words of an unfinished block at tlast are dropped. Words are
// taken one per cycle while a block is gathered; the sixteenth word starts 64
// rounds on the single shared round unit, one round per cycle, and a final
// step then adds the result into the chaining value, with input not ready
// during the rounds and that final step. A digest passes through an emit
// state into the output register, which holds it until taken while the next
// message is already gathered.

module sha256_block_compression
   import sha256c_pkg::*;
(
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic                   req_tvalid,
   output var logic                   req_tready,
   input  var logic [WORD_BITS-1:0]   req_tdata,   // [31:0] message_word
   input  var logic                   req_tuser,   // [0] restart
   input  var logic                   req_tlast,   // last_of_message
   output var logic                   rsp_tvalid,
   input  var logic                   rsp_tready,
   output var logic [DIGEST_BITS-1:0] rsp_tdata    // [63:0] digest_ab, [127:64] digest_cd,
                                                   // [191:128] digest_ef, [255:192] digest_gh
);

`include "sha256_block_compression_defines.svh"

   sha256c_state_type state_ff, state_in;

   logic [3:0]       pos_ff, pos_in;
   logic [5:0]       round_ff, round_in;
   logic             last_pend_ff, last_pend_in;
   word_type         cv_ff [STATE_LEN];
   word_type         cv_in [STATE_LEN];
   word_type         win_ff [BLOCK_LEN];
   word_type         win_in [BLOCK_LEN];
   sha256c_vars_type vars_ff, vars_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [DIGEST_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             out_free;
   logic             block_done;
   logic [3:0]       pos_eff;
   sha256c_taps_type taps;
   sha256c_vars_type vars_nxt;
   word_type         sched_word;
   word_type         round_k;

   // Flags set by the sequencer for the datapath.
   logic             do_collect;
   logic             do_round;
   logic             do_final;
   logic             do_emit;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign pos_eff  = req_tuser ? '0 : pos_ff;
   assign block_done = pos_eff == LAST_POSITION;

   assign taps.w0  = win_ff[0];
   assign taps.w1  = win_ff[1];
   assign taps.w9  = win_ff[9];
   assign taps.w14 = win_ff[14];
   assign round_k  = ROUND_K[round_ff];

   sha256c_round u_round (
      .vars_cur   (vars_ff),
      .taps       (taps),
      .round_k    (round_k),
      .vars_nxt   (vars_nxt),
      .sched_word (sched_word)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (accept) begin
               if (block_done) begin
                  state_in = ST_ROUND;
               end else if (req_tlast) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            state_in = last_pend_ff ? ST_EMIT : ST_COLLECT;
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_COLLECT;
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   // Sequencer outputs. Ready is high throughout collection, so a valid
   // word there is a beat.
   always_comb begin
      req_tready = 1'b0;
      do_collect = 1'b0;
      do_round   = 1'b0;
      do_final   = 1'b0;
      do_emit    = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            do_collect = req_tvalid;
         end
         ST_ROUND: begin
            do_round = 1'b1;
         end
         ST_FINAL: begin
            do_final = 1'b1;
         end
         ST_EMIT: begin
            do_emit = out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Datapath.
   always_comb begin
      pos_in       = pos_ff;
      round_in     = round_ff;
      last_pend_in = last_pend_ff;
      vars_in      = vars_ff;
      cv_in        = cv_ff;
      win_in       = win_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // The window shifts by one word per beat and per round, so after
      // sixteen beats word i of the block sits at index i.
      if (do_collect || do_round) begin
         for (int i = 0; i < BLOCK_LEN - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[BLOCK_LEN - 1] = do_collect ? req_tdata : sched_word;
      end

      if (do_collect) begin
         if (req_tuser) begin
            cv_in = INIT_VALUE;
         end
         if (block_done || req_tlast) begin
            pos_in = '0;
         end else begin
            pos_in = pos_eff + 4'd1;
         end
         last_pend_in = req_tlast;
         round_in     = '0;
         vars_in      = {cv_ff[0], cv_ff[1], cv_ff[2], cv_ff[3],
                         cv_ff[4], cv_ff[5], cv_ff[6], cv_ff[7]};
      end

      if (do_round) begin
         vars_in  = vars_nxt;
         round_in = round_ff + 6'd1;
      end

      if (do_final) begin
         cv_in[0] = cv_ff[0] + vars_ff.a;
         cv_in[1] = cv_ff[1] + vars_ff.b;
         cv_in[2] = cv_ff[2] + vars_ff.c;
         cv_in[3] = cv_ff[3] + vars_ff.d;
         cv_in[4] = cv_ff[4] + vars_ff.e;
         cv_in[5] = cv_ff[5] + vars_ff.f;
         cv_in[6] = cv_ff[6] + vars_ff.g;
         cv_in[7] = cv_ff[7] + vars_ff.h;
      end

      if (do_emit) begin
         for (int j = 0; j < STATE_LEN / 2; j++) begin
            rsp_data_in[j*2*WORD_BITS +: 2*WORD_BITS] = {cv_ff[2*j], cv_ff[2*j + 1]};
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         pos_ff       <= '0;
         round_ff     <= '0;
         last_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cv_ff        <= INIT_VALUE;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         round_ff     <= round_in;
         last_pend_ff <= last_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         cv_ff        <= cv_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      vars_ff     <= vars_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `SHA256C_ASSERT_NEXT(a_block_starts_rounds, accept && block_done,
      state_ff == ST_ROUND && round_ff == '0, "sixteenth word did not start the rounds")
   `SHA256C_ASSERT_NEXT(a_rounds_end, state_ff == ST_ROUND && round_ff == LAST_ROUND,
      state_ff == ST_FINAL, "rounds did not end after the last round")
   `SHA256C_ASSERT_NOW(a_pos_idle, state_ff != ST_COLLECT, pos_ff == '0,
      "word position not cleared outside collection")
   `SHA256C_ASSERT_NEXT(a_emit_loads, state_ff == ST_EMIT && out_free,
      rsp_tvalid && state_ff == ST_COLLECT, "digest not loaded into output register")

endmodule

`default_nettype wire

// File: tb/sha256_block_compression_tb.sv
// Self-checking stream testbench for the SHA-256 block compression, with its own digest predictor.
`timescale 1ns / 1ps

module sha256_block_compression_tb;
   import sha256c_pkg::*;

   typedef struct packed {
      word_type word;
      logic     restart;
      logic     last;
   } msg_beat_type;

   localparam word_type SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [WORD_BITS-1:0]   req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DIGEST_BITS-1:0] rsp_tdata;

   msg_beat_type           word_queue [$];
   logic [DIGEST_BITS-1:0] digest_queue [$];
   msg_beat_type           next_beat;

   // Predictor state: chaining value, gathered block and position in it.
   word_type               chain_value [8];
   word_type               block_buf [16];
   logic [3:0]             block_pos;

   int                     beats_total = 0;
   int                     beats_taken = 0;
   int                     error_count = 0;
   int                     traffic_phase = 0;

   sha256_block_compression u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WORD_BITS - n));
   endfunction

   function automatic void compress_block();
      word_type sched [64];
      word_type v [8];
      word_type s0, s1, ch, maj, t1, t2;
      for (int t = 0; t < 16; t++) sched[t] = block_buf[t];
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(sched[t-15], 7) ^ rotr(sched[t-15], 18) ^ (sched[t-15] >> 3);
         s1 = rotr(sched[t-2], 17) ^ rotr(sched[t-2], 19) ^ (sched[t-2] >> 10);
         sched[t] = sched[t-16] + s0 + sched[t-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = chain_value[i];
      for (int t = 0; t < 64; t++) begin
         s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
         ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
         t1 = v[7] + s1 + ch + ROUND_CONST[t] + sched[t];
         s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
         maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
         t2 = s0 + maj;
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_value[i] = chain_value[i] + v[i];
   endfunction

   // Takes one accepted word and queues the digest when the message ends.
   function automatic void absorb_word(input word_type word, input logic restart,
                                       input logic last);
      if (restart) begin
         chain_value = SHA_IV;
         block_pos = '0;
      end
      block_buf[block_pos] = word;
      block_pos = block_pos + 1'b1;
      if (block_pos == '0) compress_block();
      if (last) begin
         // A partial block is simply dropped.
         block_pos = '0;
         digest_queue.push_back({chain_value[6], chain_value[7], chain_value[4], chain_value[5],
                                 chain_value[2], chain_value[3], chain_value[0], chain_value[1]});
      end
   endfunction

   function automatic void check_digest(input logic [DIGEST_BITS-1:0] got);
      logic [DIGEST_BITS-1:0] want;
      string                  field_name [4];
      field_name = '{"digest_ab", "digest_cd", "digest_ef", "digest_gh"};
      if (digest_queue.size() == 0) begin
         $display("%0t: digest beat with none expected, actual %h", $time, got);
         error_count++;
      end else begin
         want = digest_queue.pop_front();
         for (int f = 0; f < 4; f++) begin
            if (got[f*64 +: 64] !== want[f*64 +: 64]) begin
               $display("%0t: %s expected %h actual %h", $time, field_name[f],
                        want[f*64 +: 64], got[f*64 +: 64]);
               error_count++;
            end
         end
      end
   endfunction

   function automatic bit roll_percent(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   task automatic add_beat(input word_type word, input logic restart, input logic last);
      word_queue.push_back('{word: word, restart: restart, last: last});
   endtask

   task automatic add_random_run(input int n, input bit restart_first, input bit last_end);
      for (int i = 0; i < n; i++)
         add_beat($urandom, restart_first && i == 0, last_end && i == n - 1);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      int pick;
      // The padded three-byte message "abc", sent without restart right after reset.
      add_beat(32'h61626380, 1'b0, 1'b0);
      repeat (14) add_beat(32'h00000000, 1'b0, 1'b0);
      add_beat(32'h00000018, 1'b0, 1'b1);
      // Lone word after a digest: partial block, the digest repeats.
      add_beat(32'hffffffff, 1'b0, 1'b1);
      // Restart in the middle of a block, then end at once.
      add_beat(32'h00000000, 1'b0, 1'b0);
      add_beat(32'hffffffff, 1'b1, 1'b1);
      add_beat(32'h00000000, 1'b0, 1'b0);
      add_beat(32'hffffffff, 1'b0, 1'b0);
      add_beat(32'h80000000, 1'b0, 1'b1);

      while (word_queue.size() < 1100) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            add_random_run(16, 1'b1, 1'b1);
         end else if (pick < 70) begin
            add_random_run(16 * $urandom_range(2, 3), 1'b1, 1'b1);
         end else if (pick < 80) begin
            // Continue hashing from the previous digest.
            add_random_run(16, 1'b0, 1'b1);
         end else if (pick < 90) begin
            add_random_run($urandom_range(1, 15), 1'b1, 1'b0);
            add_random_run(16, 1'b1, 1'b1);
         end else begin
            add_random_run($urandom_range(1, 15), $urandom_range(1), 1'b1);
         end
      end
      beats_total = word_queue.size();
   end

   // Driver: presents queued words and feeds the predictor on each accepted beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         chain_value = SHA_IV;
         block_pos = '0;
         beats_taken = 0;
         traffic_phase <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_word(req_tdata, req_tuser, req_tlast);
            beats_taken = beats_taken + 1;
            traffic_phase <= beats_taken * 3 / beats_total;
         end
         if (!req_tvalid || req_tready) begin
            if (word_queue.size() != 0 &&
                !roll_percent(traffic_phase == 0 ? 11 : traffic_phase == 1 ? 78 : 0)) begin
               next_beat = word_queue.pop_front();
               req_tdata  <= next_beat.word;
               req_tuser  <= next_beat.restart;
               req_tlast  <= next_beat.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each digest beat and stalls the result side at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_digest(rsp_tdata);
         rsp_tready <= !roll_percent(traffic_phase == 0 ? 78 : traffic_phase == 1 ? 11 : 0);
      end
   end

   initial begin
      do @(negedge clock);
      while (reset || beats_total == 0 || beats_taken < beats_total || digest_queue.size() != 0);
      // Let a block still in its rounds finish so a stray beat would be seen.
      repeat (100) @(negedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
